// File: hdl/nwrc_pkg.sv
// ---------------------------------------------------------------------------
// nwrc_pkg: shared types and constants for the node wake retry controller
// Configuration record, command codes and register reset values.
// ---------------------------------------------------------------------------
package nwrc_pkg;

    localparam int TIMER_BITS_DEFAULT = 24;

    localparam logic [15:0] PULSE_TICKS_RESET    = 16'd100;
    localparam logic [15:0] SETTLE_TICKS_RESET   = 16'd100;
    localparam logic [15:0] WINDOW_TICKS_RESET   = 16'd1000;
    localparam logic [3:0]  MAX_ATTEMPTS_RESET   = 4'd3;
    localparam logic [23:0] COOLDOWN_TICKS_RESET = 24'd900000;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_WAKE     = 2'd1,
        MODE_RESET_CD = 2'd2,
        MODE_SLEEP    = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [15:0] settle_ticks;
        logic [15:0] retry_window_ticks;
        logic [3:0]  max_attempts;
        logic [23:0] cooldown_ticks;
    } cfg_t;

endpackage

// File: hdl/nwrc_if.sv
// ---------------------------------------------------------------------------
// nwrc_if: item and result channels
// Valid/ready channels carrying one tick command and one status result.
// ---------------------------------------------------------------------------
interface nwrc_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       status_high;

    modport source (output valid, output mode, output status_high, input ready);
    modport sink (input valid, input mode, input status_high, output ready);
endinterface

interface nwrc_result_if;
    logic       valid;
    logic       ready;
    logic       wake_line;
    logic [2:0] node_state;
    logic [3:0] attempt_count;
    logic       wake_done;
    logic       wake_ok;

    modport source (output valid, output wake_line, output node_state,
                    output attempt_count, output wake_done, output wake_ok,
                    input ready);
    modport sink (input valid, input wake_line, input node_state,
                  input attempt_count, input wake_done, input wake_ok,
                  output ready);
endinterface

// File: hdl/nwrc_regs.sv
// ---------------------------------------------------------------------------
// nwrc_regs: configuration register file
// APB-style write and read access to the five timing registers.
// ---------------------------------------------------------------------------
module nwrc_regs
    import nwrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    localparam logic [2:0] REG_PULSE    = 3'd0;
    localparam logic [2:0] REG_SETTLE   = 3'd1;
    localparam logic [2:0] REG_WINDOW   = 3'd2;
    localparam logic [2:0] REG_ATTEMPTS = 3'd3;
    localparam logic [2:0] REG_COOLDOWN = 3'd4;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks        <= PULSE_TICKS_RESET;
            cfg_reg.settle_ticks       <= SETTLE_TICKS_RESET;
            cfg_reg.retry_window_ticks <= WINDOW_TICKS_RESET;
            cfg_reg.max_attempts       <= MAX_ATTEMPTS_RESET;
            cfg_reg.cooldown_ticks     <= COOLDOWN_TICKS_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PULSE:    cfg_reg.pulse_ticks        <= pwdata[15:0];
                REG_SETTLE:   cfg_reg.settle_ticks       <= pwdata[15:0];
                REG_WINDOW:   cfg_reg.retry_window_ticks <= pwdata[15:0];
                REG_ATTEMPTS: cfg_reg.max_attempts       <= pwdata[3:0];
                REG_COOLDOWN: cfg_reg.cooldown_ticks     <= pwdata[23:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PULSE:    prdata = {16'd0, cfg_reg.pulse_ticks};
            REG_SETTLE:   prdata = {16'd0, cfg_reg.settle_ticks};
            REG_WINDOW:   prdata = {16'd0, cfg_reg.retry_window_ticks};
            REG_ATTEMPTS: prdata = {28'd0, cfg_reg.max_attempts};
            REG_COOLDOWN: prdata = {8'd0, cfg_reg.cooldown_ticks};
            default:      prdata = 32'd0;
        endcase
    end

endmodule

// File: hdl/nwrc_core.sv
// ---------------------------------------------------------------------------
// nwrc_core: wake sequencer
// Per-tick update of phase, wake step, step timer and attempt count, with
// a registered result stage.
// ---------------------------------------------------------------------------
module nwrc_core
    import nwrc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    nwrc_item_if.sink       item,
    nwrc_result_if.source   result
);

    typedef enum logic [2:0] {
        PH_UNKNOWN  = 3'd0,
        PH_SLEEPING = 3'd1,
        PH_WAKING   = 3'd2,
        PH_AWAKE    = 3'd3,
        PH_COOLDOWN = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        WS_PULSE  = 2'd0,
        WS_WAIT   = 2'd1,
        WS_SETTLE = 2'd2,
        WS_GAP    = 2'd3
    } step_t;

    localparam int WIDE = (TIMER_BITS > 24) ? TIMER_BITS : 24;
    localparam logic [WIDE-1:0] TIMER_MAX = WIDE'({TIMER_BITS{1'b1}});
    localparam logic [3:0] ATTEMPTS_MAX = 4'd15;

    phase_t                phase_reg, phase_next;
    step_t                 step_reg, step_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [3:0]            attempts_reg, attempts_next;
    logic                  level_reg, level_next;

    logic                  out_valid_reg;
    logic                  wake_line_reg;
    logic [2:0]            node_state_reg;
    logic [3:0]            attempt_count_reg;
    logic                  wake_done_reg, wake_ok_reg;

    logic                  accept;
    logic                  done, ok;
    logic [TIMER_BITS-1:0] timer_dec;
    logic                  timer_zero;
    logic [3:0]            limit;
    logic [3:0]            attempts_inc;
    logic [WIDE-1:0]       cool_wide;
    logic [TIMER_BITS-1:0] pulse_load, settle_load, window_load, cool_load;
    mode_t                 mode;

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign mode       = mode_t'(item.mode);

    assign timer_dec    = (timer_reg != '0) ? timer_reg - 1'b1 : timer_reg;
    assign timer_zero   = (timer_dec == '0);
    assign limit        = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
    assign attempts_inc = (attempts_reg < ATTEMPTS_MAX) ? attempts_reg + 4'd1
                                                        : attempts_reg;
    assign pulse_load   = TIMER_BITS'(cfg.pulse_ticks);
    assign settle_load  = TIMER_BITS'(cfg.settle_ticks);
    assign window_load  = TIMER_BITS'(cfg.retry_window_ticks);
    assign cool_wide    = WIDE'(cfg.cooldown_ticks);
    assign cool_load    = (cool_wide > TIMER_MAX) ? TIMER_MAX[TIMER_BITS-1:0]
                                                  : cool_wide[TIMER_BITS-1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        timer_next    = timer_reg;
        attempts_next = attempts_reg;
        level_next    = level_reg;
        done          = 1'b0;
        ok            = 1'b0;

        if (phase_reg == PH_WAKING)
        begin
            unique case (step_reg)
                WS_PULSE:
                begin
                    timer_next = timer_dec;
                    if (timer_zero)
                    begin
                        level_next = 1'b0;
                        step_next  = WS_WAIT;
                        timer_next = window_load;
                    end
                end
                WS_WAIT:
                begin
                    if (item.status_high)
                    begin
                        step_next  = WS_SETTLE;
                        timer_next = settle_load;
                        if (settle_load == '0)
                        begin
                            phase_next    = PH_AWAKE;
                            attempts_next = 4'd0;
                            step_next     = WS_PULSE;
                            level_next    = 1'b0;
                            done          = 1'b1;
                            ok            = 1'b1;
                        end
                    end
                    else
                    begin
                        timer_next = timer_dec;
                        if (timer_zero)
                        begin
                            if (attempts_reg >= limit)
                            begin
                                phase_next = PH_COOLDOWN;
                                step_next  = WS_PULSE;
                                timer_next = cool_load;
                                done       = 1'b1;
                            end
                            else
                            begin
                                step_next  = WS_GAP;
                                timer_next = window_load;
                            end
                        end
                    end
                end
                WS_SETTLE:
                begin
                    timer_next = timer_dec;
                    if (timer_zero)
                    begin
                        phase_next    = PH_AWAKE;
                        attempts_next = 4'd0;
                        step_next     = WS_PULSE;
                        level_next    = 1'b0;
                        timer_next    = '0;
                        done          = 1'b1;
                        ok            = 1'b1;
                    end
                end
                WS_GAP:
                begin
                    timer_next = timer_dec;
                    if (timer_zero)
                    begin
                        attempts_next = attempts_inc;
                        step_next     = WS_PULSE;
                        level_next    = 1'b1;
                        timer_next    = pulse_load;
                    end
                end
                default: ;
            endcase
        end
        else
        begin
            unique case (mode)
                MODE_WAKE:
                begin
                    if (item.status_high)
                    begin
                        phase_next    = PH_AWAKE;
                        attempts_next = 4'd0;
                        done          = 1'b1;
                        ok            = 1'b1;
                    end
                    else if (phase_reg == PH_COOLDOWN)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_WAKING;
                        attempts_next = 4'd1;
                        step_next     = WS_PULSE;
                        level_next    = 1'b1;
                        timer_next    = pulse_load;
                    end
                end
                MODE_RESET_CD:
                begin
                    if (phase_reg == PH_COOLDOWN)
                    begin
                        phase_next    = PH_SLEEPING;
                        attempts_next = 4'd0;
                    end
                end
                MODE_SLEEP:
                begin
                    if (!item.status_high)
                        phase_next = PH_SLEEPING;
                end
                MODE_TICK:
                begin
                    if (phase_reg != PH_COOLDOWN)
                    begin
                        if (item.status_high && phase_reg != PH_AWAKE)
                        begin
                            phase_next    = PH_AWAKE;
                            attempts_next = 4'd0;
                        end
                        else if (!item.status_high && phase_reg == PH_AWAKE)
                        begin
                            phase_next = PH_SLEEPING;
                        end
                    end
                end
                default: ;
            endcase
            if (phase_next == PH_COOLDOWN)
            begin
                timer_next = timer_dec;
                if (timer_zero)
                begin
                    phase_next    = PH_SLEEPING;
                    attempts_next = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_UNKNOWN;
            step_reg      <= WS_PULSE;
            timer_reg     <= '0;
            attempts_reg  <= 4'd0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                timer_reg     <= timer_next;
                attempts_reg  <= attempts_next;
                level_reg     <= level_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wake_line_reg     <= level_next;
            node_state_reg    <= phase_next;
            attempt_count_reg <= attempts_next;
            wake_done_reg     <= done;
            wake_ok_reg       <= done & ok;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.wake_line     = wake_line_reg;
    assign result.node_state    = node_state_reg;
    assign result.attempt_count = attempt_count_reg;
    assign result.wake_done     = wake_done_reg;
    assign result.wake_ok       = wake_ok_reg;

endmodule

// File: hdl/node_wake_retry_controller_top.sv
// ---------------------------------------------------------------------------
// node_wake_retry_controller_top: node wake retry controller
// Drives a remote node's wake line with retries and cooldown, one
// millisecond tick per transaction, and tracks the node status pin.
// ---------------------------------------------------------------------------
// channel   dir   handshake        payload
// item      in    valid/ready      mode[1:0], status_high
// result    out   valid/ready      wake_line, node_state[2:0], attempt_count[3:0],
//                                  wake_done, wake_ok
// apb       in    psel/penable     paddr[4:0], pwdata[31:0], prdata[31:0]
//
// One transaction per clock unless results stall: the state update for an item
// completes in the accept cycle; the result register shows it on the next cycle.
// A new item is taken while the result register is empty or being drained.
// Reset returns the phase to unknown and the registers to their defaults.
// ---------------------------------------------------------------------------
module node_wake_retry_controller_top
    import nwrc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    nwrc_item_if.sink       item,
    nwrc_result_if.source   result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    cfg_t cfg;

    nwrc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nwrc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

// File: tb/node_wake_retry_controller_top_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// node_wake_retry_controller_top_test: self-checking bench for the wake
// retry controller
// Streams tick commands through the item channel, keeps a cycle-free model
// of the wake, retry, cooldown and status-follow behavior, and checks every
// result transaction field by field in order. Settings are written over APB
// between phases and read back. The run goes through directed cases, random
// wake sequences with noise under three handshake idling profiles, and the
// widest timer loads.
// ---------------------------------------------------------------------------
module node_wake_retry_controller_top_test;
    import nwrc_pkg::*;

    typedef enum logic [2:0] {
        NODE_UNKNOWN  = 3'd0,
        NODE_SLEEPING = 3'd1,
        NODE_WAKING   = 3'd2,
        NODE_AWAKE    = 3'd3,
        NODE_COOLDOWN = 3'd4
    } node_state_e;

    typedef enum logic [1:0] {
        STEP_PULSE  = 2'd0,
        STEP_WAIT   = 2'd1,
        STEP_SETTLE = 2'd2,
        STEP_GAP    = 2'd3
    } wake_step_e;

    typedef enum int {
        REG_PULSE    = 0,
        REG_SETTLE   = 1,
        REG_WINDOW   = 2,
        REG_ATTEMPTS = 3,
        REG_COOLDOWN = 4
    } reg_index_e;

    typedef struct packed {
        logic       wake_line;
        logic [2:0] node_state;
        logic [3:0] attempt_count;
        logic       wake_done;
        logic       wake_ok;
    } wake_status_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       status_high;
        logic       drain_first;
    } tick_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nwrc_item_if   item_ch ();
    nwrc_result_if result_ch ();

    node_wake_retry_controller_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cfg_t        model_cfg;
    node_state_e st_phase;
    wake_step_e  st_step;
    logic [23:0] st_timer;
    logic [3:0]  st_attempts;
    logic        st_level;

    tick_cmd_t    pending_ticks[$];
    wake_status_t expected_status[$];
    tick_cmd_t    next_cmd;
    wake_status_t oldest_status;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  hold_point;
    int  error_count;
    int  accepted_items;
    int  results_checked;
    int  settings_written;
    bit  item_fire;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ---------------- prediction ----------------

    function automatic bit timer_runout();
        if (st_timer != 24'd0)
            st_timer = st_timer - 24'd1;
        return st_timer == 24'd0;
    endfunction

    task automatic begin_attempt();
        if (st_attempts < 4'd15)
            st_attempts = st_attempts + 4'd1;
        st_step  = STEP_PULSE;
        st_level = 1'b1;
        st_timer = {8'd0, model_cfg.pulse_ticks};
    endtask

    task automatic complete_wake(inout logic done, inout logic ok);
        st_phase    = NODE_AWAKE;
        st_attempts = 4'd0;
        st_step     = STEP_PULSE;
        st_level    = 1'b0;
        st_timer    = 24'd0;
        done        = 1'b1;
        ok          = 1'b1;
    endtask

    task automatic predict_status(input logic [1:0] mode, input logic status);
        wake_status_t r;
        logic         done;
        logic         ok;
        logic [3:0]   limit;
        done  = 1'b0;
        ok    = 1'b0;
        limit = (model_cfg.max_attempts == 4'd0) ? 4'd1 : model_cfg.max_attempts;
        if (st_phase == NODE_WAKING)
        begin
            case (st_step)
                STEP_PULSE:
                begin
                    if (timer_runout())
                    begin
                        st_level = 1'b0;
                        st_step  = STEP_WAIT;
                        st_timer = {8'd0, model_cfg.retry_window_ticks};
                    end
                end
                STEP_WAIT:
                begin
                    if (status)
                    begin
                        st_step  = STEP_SETTLE;
                        st_timer = {8'd0, model_cfg.settle_ticks};
                        if (st_timer == 24'd0)
                            complete_wake(done, ok);
                    end
                    else if (timer_runout())
                    begin
                        if (st_attempts >= limit)
                        begin
                            st_phase = NODE_COOLDOWN;
                            st_step  = STEP_PULSE;
                            st_timer = model_cfg.cooldown_ticks;
                            done     = 1'b1;
                            ok       = 1'b0;
                        end
                        else
                        begin
                            st_step  = STEP_GAP;
                            st_timer = {8'd0, model_cfg.retry_window_ticks};
                        end
                    end
                end
                STEP_SETTLE:
                begin
                    if (timer_runout())
                        complete_wake(done, ok);
                end
                default:
                begin
                    if (timer_runout())
                        begin_attempt();
                end
            endcase
        end
        else
        begin
            case (mode)
                MODE_WAKE:
                begin
                    if (status)
                    begin
                        st_phase    = NODE_AWAKE;
                        st_attempts = 4'd0;
                        done        = 1'b1;
                        ok          = 1'b1;
                    end
                    else if (st_phase == NODE_COOLDOWN)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        st_phase    = NODE_WAKING;
                        st_attempts = 4'd0;
                        begin_attempt();
                    end
                end
                MODE_RESET_CD:
                begin
                    if (st_phase == NODE_COOLDOWN)
                    begin
                        st_phase    = NODE_SLEEPING;
                        st_attempts = 4'd0;
                    end
                end
                MODE_SLEEP:
                begin
                    if (!status)
                        st_phase = NODE_SLEEPING;
                end
                default:
                begin
                    if (st_phase != NODE_COOLDOWN)
                    begin
                        if (status && st_phase != NODE_AWAKE)
                        begin
                            st_phase    = NODE_AWAKE;
                            st_attempts = 4'd0;
                        end
                        else if (!status && st_phase == NODE_AWAKE)
                        begin
                            st_phase = NODE_SLEEPING;
                        end
                    end
                end
            endcase
            if (st_phase == NODE_COOLDOWN && timer_runout())
            begin
                st_phase    = NODE_SLEEPING;
                st_attempts = 4'd0;
            end
        end
        r.wake_line     = st_level;
        r.node_state    = st_phase;
        r.attempt_count = st_attempts;
        r.wake_done     = done;
        r.wake_ok       = done & ok;
        expected_status.push_back(r);
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_checked, name, got, want));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_status.size() == 0)
                begin
                    report_mismatch("result transaction with nothing expected");
                end
                else
                begin
                    oldest_status = expected_status.pop_front();
                    check_field("wake_line", 32'(result_ch.wake_line),
                                32'(oldest_status.wake_line));
                    check_field("node_state", 32'(result_ch.node_state),
                                32'(oldest_status.node_state));
                    check_field("attempt_count", 32'(result_ch.attempt_count),
                                32'(oldest_status.attempt_count));
                    check_field("wake_done", 32'(result_ch.wake_done),
                                32'(oldest_status.wake_done));
                    check_field("wake_ok", 32'(result_ch.wake_ok),
                                32'(oldest_status.wake_ok));
                end
                results_checked++;
            end
            item_fire = item_ch.valid && item_ch.ready;
            if (item_fire)
            begin
                predict_status(item_ch.mode, item_ch.status_high);
                accepted_items++;
            end
        end
    end

    // ---------------- driving ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!item_ch.valid || item_fire)
            begin
                if (pending_ticks.size() > 0 &&
                    !(pending_ticks[0].drain_first && expected_status.size() > 0) &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    next_cmd = pending_ticks.pop_front();
                    item_ch.valid       <= 1'b1;
                    item_ch.mode        <= next_cmd.mode;
                    item_ch.status_high <= next_cmd.status_high;
                end
                else
                begin
                    item_ch.valid       <= 1'b0;
                    item_ch.mode        <= 2'($urandom);
                    item_ch.status_high <= 1'($urandom);
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus ----------------

    task automatic push_item(input logic [1:0] mode, input logic status);
        tick_cmd_t c;
        c.mode        = mode;
        c.status_high = status;
        c.drain_first = (pending_ticks.size() == hold_point);
        pending_ticks.push_back(c);
    endtask

    task automatic push_ticks(input int count, input logic status);
        repeat (count) push_item(MODE_TICK, status);
    endtask

    task automatic write_register(input reg_index_e idx, input logic [31:0] value);
        logic [31:0] expected_rd;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 5'(int'(idx) * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PULSE:
            begin
                model_cfg.pulse_ticks = value[15:0];
                expected_rd           = {16'd0, value[15:0]};
            end
            REG_SETTLE:
            begin
                model_cfg.settle_ticks = value[15:0];
                expected_rd            = {16'd0, value[15:0]};
            end
            REG_WINDOW:
            begin
                model_cfg.retry_window_ticks = value[15:0];
                expected_rd                  = {16'd0, value[15:0]};
            end
            REG_ATTEMPTS:
            begin
                model_cfg.max_attempts = value[3:0];
                expected_rd            = {28'd0, value[3:0]};
            end
            default:
            begin
                model_cfg.cooldown_ticks = value[23:0];
                expected_rd              = {8'd0, value[23:0]};
            end
        endcase
        if (prdata !== expected_rd)
            report_mismatch($sformatf("register %0d read %0d expected %0d",
                                      int'(idx), prdata, expected_rd));
        settings_written++;
    endtask

    task automatic program_settings(input int pulse, input int settle, input int window,
                                    input int attempts, input int cooldown);
        write_register(REG_PULSE, pulse);
        write_register(REG_SETTLE, settle);
        write_register(REG_WINDOW, window);
        write_register(REG_ATTEMPTS, attempts);
        write_register(REG_COOLDOWN, cooldown);
    endtask

    task automatic program_random_settings();
        program_settings(($urandom_range(3) == 0) ? 1 : $urandom_range(1, 5),
                         $urandom_range(0, 4),
                         $urandom_range(1, 6),
                         ($urandom_range(9) == 0) ? 15 : $urandom_range(1, 4),
                         ($urandom_range(9) == 0) ? 24'hFFFFFF : $urandom_range(1, 30));
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (pending_ticks.size() != 0 || item_ch.valid || expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly wake sequences with random status and ignored commands, some noise.
    task automatic queue_random_traffic(input int target);
        int n;
        int len;
        int high_pct;
        n = 0;
        hold_point = target / 2;
        while (n < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                push_item(MODE_WAKE, ($urandom_range(9) == 0));
                len = $urandom_range(1, 40);
                case ($urandom_range(3))
                    0:       high_pct = 0;
                    1:       high_pct = 3;
                    2:       high_pct = 10;
                    default: high_pct = 30;
                endcase
                repeat (len)
                begin
                    push_item(($urandom_range(3) == 0) ? 2'($urandom) : MODE_TICK,
                              ($urandom_range(99) < high_pct));
                end
                n += len + 1;
                len = $urandom_range(1, 4);
                repeat (len) push_item(2'($urandom), 1'($urandom));
                n += len;
            end
            else
            begin
                len = $urandom_range(1, 5);
                repeat (len) push_item(2'($urandom), 1'($urandom));
                n += len;
            end
        end
        hold_point = -1;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = 5'd0;
        pwdata              = 32'd0;
        item_ch.valid       = 1'b0;
        item_ch.mode        = MODE_TICK;
        item_ch.status_high = 1'b0;
        result_ch.ready     = 1'b0;
        error_count         = 0;
        accepted_items      = 0;
        results_checked     = 0;
        settings_written    = 0;
        item_fire           = 1'b0;
        hold_point          = -1;
        send_idle_pct       = 21;
        recv_idle_pct       = 70;

        model_cfg.pulse_ticks        = PULSE_TICKS_RESET;
        model_cfg.settle_ticks       = SETTLE_TICKS_RESET;
        model_cfg.retry_window_ticks = WINDOW_TICKS_RESET;
        model_cfg.max_attempts       = MAX_ATTEMPTS_RESET;
        model_cfg.cooldown_ticks     = COOLDOWN_TICKS_RESET;
        st_phase    = NODE_UNKNOWN;
        st_step     = STEP_PULSE;
        st_timer    = 24'd0;
        st_attempts = 4'd0;
        st_level    = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // status follow from unknown, ignored commands, then one wake on defaults
        push_item(MODE_TICK, 1'b0);
        push_item(MODE_SLEEP, 1'b1);
        push_item(MODE_RESET_CD, 1'b0);
        push_item(MODE_TICK, 1'b1);
        push_item(MODE_TICK, 1'b0);
        push_item(MODE_WAKE, 1'b1);
        push_item(MODE_SLEEP, 1'b0);
        push_item(MODE_WAKE, 1'b0);
        push_ticks(104, 1'b0);
        push_item(MODE_RESET_CD, 1'b1);
        push_ticks(102, 1'b0);
        push_item(MODE_TICK, 1'b0);
        wait_drained();

        program_settings(2, 0, 3, 2, 40);
        // wake ended by status high in the window, then wake, no status follow, reset command
        push_item(MODE_WAKE, 1'b0);
        push_item(MODE_SLEEP, 1'b0);
        push_item(MODE_RESET_CD, 1'b0);
        push_item(MODE_WAKE, 1'b1);
        push_ticks(17, 1'b0);
        push_item(MODE_WAKE, 1'b0);
        push_item(MODE_TICK, 1'b1);
        push_item(MODE_SLEEP, 1'b1);
        push_item(MODE_RESET_CD, 1'b0);
        // fail into cooldown, leave by confirm sleep with attempts kept
        push_item(MODE_WAKE, 1'b0);
        push_ticks(20, 1'b0);
        push_item(MODE_SLEEP, 1'b0);
        // fail again, wake with status high in cooldown
        push_item(MODE_WAKE, 1'b0);
        push_ticks(20, 1'b0);
        push_item(MODE_WAKE, 1'b1);
        // fail again, let the cooldown run out
        push_item(MODE_WAKE, 1'b0);
        push_ticks(60, 1'b0);
        // zero settle: status high in the window finishes at once
        push_item(MODE_WAKE, 1'b0);
        push_ticks(3, 1'b0);
        pending_ticks.push_back('{mode: MODE_TICK, status_high: 1'b1, drain_first: 1'b1});
        push_item(MODE_TICK, 1'b0);
        wait_drained();

        repeat (3)
        begin
            program_random_settings();
            queue_random_traffic(75);
            wait_drained();
        end

        send_idle_pct = 70;
        recv_idle_pct = 21;
        repeat (3)
        begin
            program_random_settings();
            queue_random_traffic(75);
            wait_drained();
        end

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3)
        begin
            program_random_settings();
            queue_random_traffic(75);
            wait_drained();
        end

        // fifteen attempts into the longest cooldown, then leave by command
        program_settings(1, 65535, 1, 15, 24'hFFFFFF);
        push_item(MODE_WAKE, 1'b0);
        push_ticks(50, 1'b0);
        push_item(MODE_WAKE, 1'b0);
        push_item(MODE_RESET_CD, 1'b1);
        push_item(MODE_TICK, 1'b0);
        wait_drained();

        // widest pulse, window and settle loads; hold the pulse for a while
        program_settings(65535, 65535, 65535, 1, 24'hFFFFFF);
        push_item(MODE_WAKE, 1'b0);
        push_ticks(20, 1'b0);
        push_item(MODE_TICK, 1'b1);
        wait_drained();

        repeat (10) @(posedge clk);
        if (expected_status.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_status.size()));
        $display("covered %0d transactions and %0d checked results over %0d register writes",
                 accepted_items, results_checked, settings_written);
        $display("directed wake, retry, cooldown and widest-timer cases, random wake traffic");
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("%0d mismatches", error_count);
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", expected_status.size());
        $display("status: fail");
        $finish;
    end

endmodule
